// ----- rtl/cog_pkg.sv -----
// ----------------------------------------------------------------------------
// cog_pkg
// Shared types, fixed-point constants and the arctangent table of the
// circular orbit generator.
// ----------------------------------------------------------------------------
package cog_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_FRAC     = 24;
	localparam int UNIT_FRAC    = 30;

	// widths of ports and datapath
	localparam int RADIUS_W = 31;
	localparam int COORD_W  = 32;
	localparam int SPEED_W  = 32;
	localparam int ANGLE_W  = 25;
	localparam int HEAD_W   = 26;
	localparam int DT_W     = 16;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam int UNIT_W = 34;                 // cordic x / y, Q2.30 with headroom
	localparam int Z_W    = 32;                 // residual angle, degrees Q24
	localparam int CNT_W  = $clog2(CORDIC_STEPS + 1);
	localparam int MA_W   = UNIT_W;
	localparam int MB_W   = 16;
	localparam int MP_W   = MA_W + MB_W + 1;
	localparam int ACC_W  = UNIT_W + RADIUS_W;
	localparam int WRAP_W = 32;
	localparam int WRAP_STEPS = 8;

	localparam longint ONE_DEG = longint'(1) << FRAC_BITS;

	localparam logic [WRAP_W-1:0] FULL_TURN    = WRAP_W'(360 * ONE_DEG);
	localparam logic [HEAD_W-1:0] HALF_TURN    = HEAD_W'(180 * ONE_DEG);
	localparam logic [ANGLE_W-1:0] DEG_45      = ANGLE_W'(45 * ONE_DEG);
	localparam logic [ANGLE_W-1:0] DEG_135     = ANGLE_W'(135 * ONE_DEG);
	localparam logic [ANGLE_W-1:0] DEG_225     = ANGLE_W'(225 * ONE_DEG);
	localparam logic [ANGLE_W-1:0] DEG_315     = ANGLE_W'(315 * ONE_DEG);
	localparam logic signed [HEAD_W-1:0] QUARTER = HEAD_W'(90 * ONE_DEG);
	// a multiple of a full turn that lifts any negative sum above zero
	localparam logic signed [WRAP_W:0] TURN_LIFT =
		(WRAP_W + 1)'(360 * ONE_DEG * (longint'(1) << (WRAP_STEPS - 1)));

	localparam logic signed [UNIT_W-1:0] CORDIC_GAIN = UNIT_W'(652032874);
	localparam logic signed [ACC_W-1:0]  ROUND_HALF  = ACC_W'(1) << (UNIT_FRAC - 1);

	localparam logic signed [Z_W-1:0] ATAN_DEG_Q24 [24] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS     = 3'd0,
		REG_CENTER_X   = 3'd1,
		REG_CENTER_Y   = 3'd2,
		REG_CENTER_Z   = 3'd3,
		REG_SPEED      = 3'd4,
		REG_START_ANGLE = 3'd5
	} cog_reg_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [CNT_W-1:0] idx;
	} cog_cordic_ctl_t;

endpackage

// ----- rtl/cog_mul.sv -----
// ----------------------------------------------------------------------------
// cog_mul
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cog_mul import cog_pkg::*; (
	input  logic                    clk,
	input  logic signed [MA_W-1:0]  a,
	input  logic        [MB_W-1:0]  b,
	output logic signed [MP_W-1:0]  p_q
);

	logic signed [MB_W:0] b_s;

	assign b_s = $signed({1'b0, b});

	always_ff @(posedge clk) begin
		p_q <= MP_W'(a) * MP_W'(b_s);
	end

endmodule

// ----- rtl/cog_cordic.sv -----
// ----------------------------------------------------------------------------
// cog_cordic
// Rotation-mode cordic in degrees, one micro-rotation per cycle while ctl.step is set.
// ----------------------------------------------------------------------------
module cog_cordic import cog_pkg::*; (
	input  logic                     clk,
	input  cog_cordic_ctl_t          ctl,
	input  logic signed [Z_W-1:0]    z_init,
	output logic signed [UNIT_W-1:0] x,
	output logic signed [UNIT_W-1:0] y
);

	logic signed [UNIT_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [UNIT_W-1:0] x_sh, y_sh;
	logic signed [Z_W-1:0]    atan;

	assign x_sh = x_q >>> ctl.idx;
	assign y_sh = y_q >>> ctl.idx;
	assign atan = ATAN_DEG_Q24[ctl.idx];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z_init;
		end else if (ctl.step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

// ----- rtl/circular_orbit_generator_top.sv -----
// ----------------------------------------------------------------------------
// circular_orbit_generator_top
// Phase accumulator with modulo-360 wrap, cordic sine/cosine and scaling of
// the unit vector by the orbit radius around the configured center.
// ----------------------------------------------------------------------------
// flow: in_stall stays high from the taken beat until its result is placed on
//   the output; 8 wrap steps, 16 cordic steps and 5 passes through the shared
//   multiplier run one after another
// reset: registers load their defaults, the angle clears to zero, no result
//   pending; a start_angle write reloads the angle at once
module circular_orbit_generator_top import cog_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [DT_W-1:0]            dt,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [COORD_W-1:0]  pos_x,
	output logic signed [COORD_W-1:0]  pos_y,
	output logic signed [COORD_W-1:0]  pos_z,
	output logic [HEAD_W-1:0]          heading,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ADD  = 11'b000_0000_0010,
		ST_WRAP = 11'b000_0000_0100,
		ST_QUAD = 11'b000_0000_1000,
		ST_ROT  = 11'b000_0001_0000,
		ST_MXL  = 11'b000_0010_0000,
		ST_MXH  = 11'b000_0100_0000,
		ST_MYL  = 11'b000_1000_0000,
		ST_MYH  = 11'b001_0000_0000,
		ST_YACC = 11'b010_0000_0000,
		ST_OUT  = 11'b100_0000_0000
	} state_t;

	state_t                     state_q;
	logic [RADIUS_W-1:0]        radius_q;
	logic signed [COORD_W-1:0]  center_x_q, center_y_q, center_z_q;
	logic signed [SPEED_W-1:0]  speed_q;
	logic [ANGLE_W-1:0]         phase_q;
	logic [WRAP_W-1:0]          wrap_q;
	logic [2:0]                 wstep_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [1:0]                 quad_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [COORD_W-1:0]  posx_q;

	logic                       in_beat, out_beat;
	logic signed [MA_W-1:0]     mul_a;
	logic [MB_W-1:0]            mul_b;
	logic signed [MP_W-1:0]     mul_q;
	cog_cordic_ctl_t            cctl;
	logic signed [Z_W-1:0]      z_init;
	logic signed [UNIT_W-1:0]   cx, cy, unit_c, unit_s;
	logic signed [WRAP_W:0]     sum;
	logic signed [SPEED_W-1:0]  delta;
	logic [WRAP_W-1:0]          wrap_lim;
	logic [2:0]                 qraw;
	logic signed [HEAD_W-1:0]   resid;
	logic [ANGLE_W-1:0]         start_wr;
	logic [MB_W-1:0]            r_lo, r_hi;

	function automatic logic signed [COORD_W-1:0] place(
		input logic signed [ACC_W-1:0]   acc,
		input logic signed [COORD_W-1:0] center
	);
		logic signed [COORD_W+3:0] s;
		s = (COORD_W + 4)'($signed(acc[ACC_W-1:UNIT_FRAC])) + (COORD_W + 4)'(center);
		if (s > $signed((COORD_W + 4)'({1'b0, {(COORD_W-1){1'b1}}})))
			return {1'b0, {(COORD_W-1){1'b1}}};
		else if (s < -$signed((COORD_W + 4)'({1'b1, {(COORD_W-1){1'b0}}})))
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return s[COORD_W-1:0];
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	assign r_lo = radius_q[MB_W-1:0];
	assign r_hi = MB_W'(radius_q[RADIUS_W-1:MB_W]);

	// quadrant swap / negate of the cordic pair
	always_comb begin
		case (quad_q)
			2'd0: begin unit_c = cx;  unit_s = cy;  end
			2'd1: begin unit_c = -cy; unit_s = cx;  end
			2'd2: begin unit_c = -cx; unit_s = -cy; end
			default: begin unit_c = cy; unit_s = -cx; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin mul_a = MA_W'(speed_q); mul_b = dt;   end
			ST_MXL:  begin mul_a = unit_c;         mul_b = r_lo; end
			ST_MXH:  begin mul_a = unit_c;         mul_b = r_hi; end
			ST_MYL:  begin mul_a = unit_s;         mul_b = r_lo; end
			ST_MYH:  begin mul_a = unit_s;         mul_b = r_hi; end
			default: begin mul_a = '0;             mul_b = '0;   end
		endcase
	end

	cog_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_q)
	);

	// floor of speed * dt / 2^16
	assign delta = mul_q[FRAC_BITS+SPEED_W-1:FRAC_BITS];
	assign sum   = (WRAP_W + 1)'($signed({1'b0, phase_q})) + (WRAP_W + 1)'(delta);
	assign wrap_lim = FULL_TURN << wstep_q;

	// nearest multiple of 90 degrees and the residual
	always_comb begin
		if (phase_q >= DEG_315)
			qraw = 3'd4;
		else if (phase_q >= DEG_225)
			qraw = 3'd3;
		else if (phase_q >= DEG_135)
			qraw = 3'd2;
		else if (phase_q >= DEG_45)
			qraw = 3'd1;
		else
			qraw = 3'd0;
		resid  = $signed({1'b0, phase_q}) - HEAD_W'(QUARTER * $signed({1'b0, qraw}));
		z_init = Z_W'(resid) <<< (TAB_FRAC - FRAC_BITS);
	end

	assign cctl.load = (state_q == ST_QUAD);
	assign cctl.step = (state_q == ST_ROT);
	assign cctl.idx  = cnt_q;

	cog_cordic u_cordic (
		.clk    (clk),
		.ctl    (cctl),
		.z_init (z_init),
		.x      (cx),
		.y      (cy)
	);

	assign start_wr = (ANGLE_W'(cfg_data) >= ANGLE_W'(FULL_TURN)) ?
		ANGLE_W'(cfg_data) - ANGLE_W'(FULL_TURN) : ANGLE_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			radius_q   <= RADIUS_W'(655360);
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			speed_q    <= SPEED_W'(11796480);
			phase_q    <= '0;
			wstep_q    <= '0;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (out_beat && state_q != ST_OUT)
				out_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS:      radius_q   <= cfg_data[RADIUS_W-1:0];
					REG_CENTER_X:    center_x_q <= cfg_data;
					REG_CENTER_Y:    center_y_q <= cfg_data;
					REG_CENTER_Z:    center_z_q <= cfg_data;
					REG_SPEED:       speed_q    <= cfg_data;
					REG_START_ANGLE: phase_q    <= start_wr;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					wstep_q <= 3'(WRAP_STEPS - 1);
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (wstep_q == '0) begin
						phase_q <= (wrap_q >= wrap_lim) ? ANGLE_W'(wrap_q - wrap_lim) :
							ANGLE_W'(wrap_q);
						state_q <= ST_QUAD;
					end
					wstep_q <= wstep_q - 3'd1;
				end
				ST_QUAD: begin
					cnt_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
						state_q <= ST_MXL;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_MXL:  state_q <= ST_MXH;
				ST_MXH:  state_q <= ST_MYL;
				ST_MYL:  state_q <= ST_MYH;
				ST_MYH:  state_q <= ST_YACC;
				ST_YACC: state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the previous beat has left
					if (!(out_valid && out_stall)) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ADD: begin
				if (sum[WRAP_W])
					wrap_q <= WRAP_W'(sum + TURN_LIFT);
				else
					wrap_q <= sum[WRAP_W-1:0];
			end
			ST_WRAP: begin
				if (wrap_q >= wrap_lim)
					wrap_q <= wrap_q - wrap_lim;
			end
			ST_QUAD: quad_q <= qraw[1:0];
			ST_MXH:  acc_q <= ROUND_HALF + ACC_W'(mul_q);
			ST_MYL:  acc_q <= acc_q + (ACC_W'(mul_q) <<< MB_W);
			ST_MYH: begin
				posx_q <= place(acc_q, center_x_q);
				acc_q  <= ROUND_HALF + ACC_W'(mul_q);
			end
			ST_YACC: acc_q <= acc_q + (ACC_W'(mul_q) <<< MB_W);
			ST_OUT: begin
				if (!(out_valid && out_stall)) begin
					pos_x <= posx_q;
					pos_y <= place(acc_q, center_y_q);
					pos_z <= center_z_q;
					heading <= (speed_q[SPEED_W-1] || speed_q == '0) ?
						HEAD_W'(phase_q) + HALF_TURN : HEAD_W'(phase_q);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- tb/tb_circular_orbit_generator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_orbit_generator_top
// Drives dt beats into the orbit generator and compares every result beat
// against a cycle-free predictor of the phase accumulator, the degree-based
// cordic and the saturating scale-and-offset, across many register settings
// and with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_circular_orbit_generator_top import cog_pkg::*; ();

	localparam longint CLK_PERIOD   = 12;
	localparam longint LIMIT_CYCLES = 800_000;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     SETTLE       = 40;

	localparam longint TURN    = 360 * ONE_DEG;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	// indexes past the register list, the block must ignore them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [HEAD_W-1:0]         heading;
	} orbit_point_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [DT_W-1:0]           dt = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [HEAD_W-1:0]         heading;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;

	// predictor copy of registers and angle, at reset values
	logic [RADIUS_W-1:0]       pred_radius = RADIUS_W'(10 * ONE_DEG);
	logic signed [COORD_W-1:0] m_cx = '0;
	logic signed [COORD_W-1:0] m_cy = '0;
	logic signed [COORD_W-1:0] m_cz = '0;
	logic signed [SPEED_W-1:0] m_speed = SPEED_W'(180 * ONE_DEG);
	logic [ANGLE_W-1:0]        m_start = '0;
	logic [ANGLE_W-1:0]        m_phase = '0;

	logic [DT_W-1:0] dt_backlog[$];
	orbit_point_t    orbit_expect_q[$];
	orbit_point_t    got_point;
	orbit_point_t    want_point;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	bit hold_armed      = 1'b0;
	int hold_count      = 0;
	logic hold_active;

	int mismatches  = 0;
	int beats_in    = 0;
	int beats_out   = 0;
	int reg_writes  = 0;
	int held_inputs = 0;

	circular_orbit_generator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dt        (dt),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.heading   (heading),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// cos/sin in Q2.30 times radius, rounded half up, plus center, saturated
	function automatic logic signed [COORD_W-1:0] place(input longint unit,
			input logic signed [COORD_W-1:0] center);
		longint v;
		v = longint'(center) +
			((unit * longint'(pred_radius) + (longint'(1) << (UNIT_FRAC - 1))) >>> UNIT_FRAC);
		if (v > POS_MAX)
			v = POS_MAX;
		if (v < POS_MIN)
			v = POS_MIN;
		return v[COORD_W-1:0];
	endfunction

	// advances the kept angle by speed * dt and returns the new orbit point
	function automatic orbit_point_t step_orbit(input logic [DT_W-1:0] step);
		longint       delta, angle, qraw, zres, x, y, nx, c, s, head;
		orbit_point_t pt;
		delta = (longint'(m_speed) * longint'(step)) >>> FRAC_BITS;
		angle = (longint'(m_phase) + delta) % TURN;
		if (angle < 0)
			angle += TURN;
		m_phase = angle[ANGLE_W-1:0];

		// nearest quarter turn plus a residual in [-45, 45) degrees
		qraw = (angle + 45 * ONE_DEG) / (90 * ONE_DEG);
		zres = (angle - qraw * 90 * ONE_DEG) * (longint'(1) << (TAB_FRAC - FRAC_BITS));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (zres >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				zres -= longint'(ATAN_DEG_Q24[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				zres += longint'(ATAN_DEG_Q24[i]);
			end
			x = nx;
		end
		case (qraw[1:0])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase

		head = angle;
		if (m_speed <= 0)
			head += 180 * ONE_DEG;
		pt.pos_x = place(c, m_cx);
		pt.pos_y = place(s, m_cy);
		pt.pos_z = m_cz;
		pt.heading = head[HEAD_W-1:0];
		return pt;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// driver: offers the next pending dt, predicts at acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				orbit_expect_q.push_back(step_orbit(dt));
				beats_in++;
			end
			if (in_valid && in_stall && hold_active)
				held_inputs++;
			if (!in_valid || !in_stall) begin
				if (dt_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					dt <= dt_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, counted here while armed
	always @(posedge clk) begin
		if (!hold_armed)
			hold_count <= 0;
		else if (hold_count < HOLD_CYCLES)
			hold_count <= hold_count + 1;
	end
	assign hold_active = hold_armed && (hold_count < HOLD_CYCLES);

	// monitor: compares each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				beats_out++;
				got_point = '{pos_x, pos_y, pos_z, heading};
				if (orbit_expect_q.size() == 0) begin
					$error("result beat with no prediction pending: x %0d y %0d z %0d heading %0d",
						pos_x, pos_y, pos_z, heading);
					mismatches++;
				end else begin
					want_point = orbit_expect_q.pop_front();
					check_field("pos_x", longint'(want_point.pos_x),
						longint'(got_point.pos_x));
					check_field("pos_y", longint'(want_point.pos_y),
						longint'(got_point.pos_y));
					check_field("pos_z", longint'(want_point.pos_z),
						longint'(got_point.pos_z));
					check_field("heading", longint'(want_point.heading),
						longint'(got_point.heading));
				end
			end
			out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_RADIUS:   pred_radius = val[RADIUS_W-1:0];
			REG_CENTER_X: m_cx = val;
			REG_CENTER_Y: m_cy = val;
			REG_CENTER_Z: m_cz = val;
			REG_SPEED:    m_speed = val;
			REG_START_ANGLE: begin
				m_start = val[ANGLE_W-1:0];
				m_phase = ANGLE_W'(longint'(m_start) % TURN);
			end
			default: ;
		endcase
	endtask

	task automatic set_orbit(input logic [CFG_W-1:0] radius, cx, cy, cz, speed, start);
		write_reg(REG_RADIUS, radius);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_SPEED, speed);
		write_reg(REG_START_ANGLE, start);
	endtask

	// runs the queued beats and waits until every result is back
	task automatic drain(input int snd_pct, input int rcv_pct);
		sender_idle_pct = snd_pct;
		recv_stall_pct = rcv_pct;
		while (dt_backlog.size() > 0 || in_valid || orbit_expect_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_signed();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4: return $urandom;
			default: return CFG_W'($signed($urandom_range(0, 400 * ONE_DEG)) - 200 * ONE_DEG);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_radius();
		case ($urandom_range(5))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 200 * ONE_DEG);
		endcase
	endfunction

	initial begin
		int snd, rcv, n;
		logic [DT_W-1:0] d;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero step, full step, half and quarter second, one lsb
		dt_backlog = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h4000};
		drain(0, 0);

		// all extremes at once, start angle above a full turn, many turns per beat
		set_orbit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h01FF_FFFF);
		dt_backlog = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
		drain(0, 0);

		// most negative speed, zero radius
		set_orbit('0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		dt_backlog = '{16'hFFFF, 16'h0001, 16'h8000};
		drain(0, 0);

		// zero speed, angle on a quadrant boundary
		set_orbit(CFG_W'(ONE_DEG), CFG_W'(ONE_DEG), CFG_W'(-ONE_DEG), '0, '0,
			CFG_W'(45 * ONE_DEG));
		dt_backlog = '{16'h0000, 16'hFFFF};
		drain(0, 0);

		// 270 plus 90 lands on exactly 360
		set_orbit(CFG_W'(100 * ONE_DEG), '0, '0, '0, CFG_W'(180 * ONE_DEG),
			CFG_W'(270 * ONE_DEG));
		dt_backlog = '{16'h8000, 16'h8000, 16'h8000};
		drain(0, 0);

		// small negative step wraps below zero; start at exactly 360; spare indexes
		set_orbit(CFG_W'(50 * ONE_DEG), 32'h0123_4567, 32'hFEDC_BA98, 32'h1357_9BDF,
			CFG_W'(-90 * ONE_DEG), CFG_W'(360 * ONE_DEG));
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		dt_backlog = '{16'h0001, 16'hFFFF};
		drain(0, 0);

		for (int p = 0; p < 8; p++) begin
			set_orbit(pick_radius(), pick_signed(), pick_signed(), pick_signed(),
				pick_signed(), $urandom);
			if ($urandom_range(3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_A, REG_SPARE_B)), $urandom);
			n = $urandom_range(170, 190);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(15))
					0: d = '0;
					1: d = '1;
					default: d = DT_W'($urandom_range(0, 65535));
				endcase
				dt_backlog.push_back(d);
			end
			case (p % 4)
				0: begin snd = 0;  rcv = 0;  end
				1: begin snd = 51; rcv = 0;  end
				2: begin snd = 0;  rcv = 51; end
				default: begin snd = 36; rcv = 36; end
			endcase
			// output held off while the sender keeps offering beats
			hold_armed = (p == 4);
			drain(snd, rcv);
			hold_armed = 1'b0;
		end

		repeat (SETTLE) @(posedge clk);
		$display("covered %0d dt beats and %0d orbit results over %0d register writes",
			beats_in, beats_out, reg_writes);
		$display("input held back %0d cycles while the output was stalled for %0d cycles",
			held_inputs, HOLD_CYCLES);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d predictions pending", orbit_expect_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
